/* rtl/stq_pkg.sv */
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TICK_BITS   = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_RUNNING = 3'd1,
        STAT_IDLE    = 3'd2,
        STAT_ZERO    = 3'd3,
        STAT_EXPIRED = 3'd4,
        STAT_NONE    = 3'd5
    } t_status;

    typedef struct packed {
        t_mode       mode;
        logic [3:0]  slot;
        logic [23:0] delay_ticks;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  slot_out;
        logic [31:0] now;
        logic        last;
    } t_res;

    typedef struct packed {
        logic                 valid;
        logic [SLOT_W-1:0]    slot;
        logic [TICK_BITS-1:0] expiry;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SHIFT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [SLOT_W-1:0]    slot;
        logic [TICK_BITS-1:0] expiry;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_REQ  = 2'd1,
        S_TICK = 2'd2
    } t_state;

    // Fold the 4-bit slot field into the bank.
    function automatic logic [SLOT_W-1:0] slot_index(input logic [3:0] slot);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (slot == 4'(i)) begin
                r = SLOT_W'(i % TIMER_SLOTS);
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] slot_out4(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W+3:0] ext;
        ext = (SLOT_W + 4)'(slot);
        return ext[3:0];
    endfunction

endpackage

/* rtl/stq_cell.sv */
module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_cmd i_cmd,
    input  stq_pkg::t_entry    i_prev_ent,
    input  logic               i_prev_keep,
    input  logic               i_prev_rm,
    input  stq_pkg::t_entry    i_next_ent,
    output stq_pkg::t_entry    o_ent,
    output logic               o_keep,
    output logic               o_rm,
    output logic               o_match
);

    logic                          r_valid;
    logic                          n_valid;
    logic [stq_pkg::SLOT_W-1:0]    r_slot;
    logic [stq_pkg::SLOT_W-1:0]    n_slot;
    logic [stq_pkg::TICK_BITS-1:0] r_expiry;
    logic [stq_pkg::TICK_BITS-1:0] n_expiry;

    assign o_ent   = '{valid: r_valid, slot: r_slot, expiry: r_expiry};
    assign o_match = r_valid && (r_slot == i_cmd.slot);
    // Entries earlier than the new expiry stay put on insert.
    assign o_keep  = r_valid && (r_expiry < i_cmd.expiry);
    // Everything at or behind the removed entry moves one place forward.
    assign o_rm    = i_prev_rm || o_match;

    always_comb begin
        n_valid  = r_valid;
        n_slot   = r_slot;
        n_expiry = r_expiry;
        case (i_cmd.op)
            stq_pkg::CELL_INSERT: begin
                if (!o_keep) begin
                    if (i_prev_keep) begin
                        n_valid  = 1'b1;
                        n_slot   = i_cmd.slot;
                        n_expiry = i_cmd.expiry;
                    end else begin
                        n_valid  = i_prev_ent.valid;
                        n_slot   = i_prev_ent.slot;
                        n_expiry = i_prev_ent.expiry;
                    end
                end
            end
            stq_pkg::CELL_REMOVE: begin
                if (o_rm) begin
                    n_valid  = i_next_ent.valid;
                    n_slot   = i_next_ent.slot;
                    n_expiry = i_next_ent.expiry;
                end
            end
            stq_pkg::CELL_SHIFT: begin
                n_valid  = i_next_ent.valid;
                n_slot   = i_next_ent.slot;
                n_expiry = i_next_ent.expiry;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_expiry <= n_expiry;
    end

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_prev_ent.valid |-> i_prev_ent.expiry <= r_expiry)
        else $error("expiry order broken between neighbor cells");

endmodule

/* rtl/sorted_timer_expiry_queue.sv */
// Timer slots held as a chain of cells sorted by expiry, the front cell due
// first. A beat is taken when start is high and busy is low. Start and stop
// requests give one result via the S_REQ state and the strobe register and
// free the block when S_REQ ends; a tick gives one result per cycle for each
// due slot (up to sixteen, or one "none expired" result) via the S_TICK
// state and the strobe register. Every result sits on o_res for a single
// cycle with o_strobe high and cannot be held off, so the receiver must take
// it then; last marks the final result of a beat. Each request costs one
// pass of the chain, each expiry one shift of the chain toward the front.
module sorted_timer_expiry_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  stq_pkg::t_req i_req,
    output logic          o_strobe,
    output stq_pkg::t_res o_res
);

    localparam int N = stq_pkg::TIMER_SLOTS;

    stq_pkg::t_state               r_state;
    stq_pkg::t_state               n_state;
    stq_pkg::t_req                 r_req;
    stq_pkg::t_req                 n_req;
    logic [stq_pkg::TICK_BITS-1:0] r_tick;
    logic [stq_pkg::TICK_BITS-1:0] n_tick;
    logic [stq_pkg::CNT_W-1:0]     r_count;
    logic [stq_pkg::CNT_W-1:0]     n_count;
    logic                          r_strobe;
    logic                          n_strobe;
    stq_pkg::t_res                 r_res;
    stq_pkg::t_res                 n_res;

    stq_pkg::t_cell_cmd w_cmd;
    stq_pkg::t_entry    w_ent [N];
    logic [N-1:0]       w_keep;
    logic [N-1:0]       w_rm;
    logic [N-1:0]       w_match;
    logic [N-1:0]       w_valid;
    logic               w_accept;
    logic               w_running;
    logic               w_head_due;
    logic               w_next_due;
    logic               w_tick_done;
    logic [stq_pkg::TICK_BITS+31:0] w_now_ext;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            stq_pkg::t_entry w_prev;
            stq_pkg::t_entry w_next;
            logic            w_prev_keep;
            logic            w_prev_rm;
            if (g == 0) begin : g_front
                assign w_prev      = '0;
                assign w_prev_keep = 1'b1;
                assign w_prev_rm   = 1'b0;
            end else begin : g_mid
                assign w_prev      = w_ent[g-1];
                assign w_prev_keep = w_keep[g-1];
                assign w_prev_rm   = w_rm[g-1];
            end
            if (g == N - 1) begin : g_back
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_ent[g+1];
            end
            stq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_prev_ent (w_prev),
                .i_prev_keep(w_prev_keep),
                .i_prev_rm  (w_prev_rm),
                .i_next_ent (w_next),
                .o_ent      (w_ent[g]),
                .o_keep     (w_keep[g]),
                .o_rm       (w_rm[g]),
                .o_match    (w_match[g])
            );
            assign w_valid[g] = w_ent[g].valid;
        end
    endgenerate

    assign busy        = (r_state != stq_pkg::S_IDLE);
    assign w_accept    = start && !busy;
    assign w_running   = |w_match;
    assign w_head_due  = w_ent[0].valid && (w_ent[0].expiry <= r_tick);
    assign w_next_due  = w_ent[1].valid && (w_ent[1].expiry <= r_tick);
    assign w_tick_done = !w_head_due || !w_next_due
                         || (r_count == stq_pkg::CNT_W'(stq_pkg::MAX_RESULTS - 1));
    assign w_now_ext   = (stq_pkg::TICK_BITS + 32)'(r_tick);

    always_comb begin
        n_state = r_state;
        case (r_state)
            stq_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_req.mode == stq_pkg::MODE_TICK) begin
                        n_state = stq_pkg::S_TICK;
                    end else if (i_req.mode == stq_pkg::MODE_START
                                 || i_req.mode == stq_pkg::MODE_STOP) begin
                        n_state = stq_pkg::S_REQ;
                    end
                end
            end
            stq_pkg::S_REQ: begin
                n_state = stq_pkg::S_IDLE;
            end
            stq_pkg::S_TICK: begin
                if (w_tick_done) begin
                    n_state = stq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_req          = r_req;
        n_tick         = r_tick;
        n_count        = r_count;
        n_strobe       = 1'b0;
        n_res          = r_res;
        n_res.now      = w_now_ext[31:0];
        w_cmd.op       = stq_pkg::CELL_HOLD;
        w_cmd.slot     = stq_pkg::slot_index(r_req.slot);
        w_cmd.expiry   = r_tick + stq_pkg::TICK_BITS'(r_req.delay_ticks);
        case (r_state)
            stq_pkg::S_IDLE: begin
                n_count = '0;
                if (w_accept) begin
                    n_req = i_req;
                    if (i_req.mode == stq_pkg::MODE_TICK) begin
                        n_tick = r_tick + stq_pkg::TICK_BITS'(1);
                    end
                end
            end
            stq_pkg::S_REQ: begin
                n_strobe       = 1'b1;
                n_res.slot_out = r_req.slot;
                n_res.last     = 1'b1;
                case (r_req.mode)
                    stq_pkg::MODE_START: begin
                        if (w_running) begin
                            n_res.status = stq_pkg::STAT_RUNNING;
                        end else if (r_req.delay_ticks == '0) begin
                            n_res.status = stq_pkg::STAT_ZERO;
                        end else begin
                            w_cmd.op     = stq_pkg::CELL_INSERT;
                            n_res.status = stq_pkg::STAT_OK;
                        end
                    end
                    stq_pkg::MODE_STOP: begin
                        if (w_running) begin
                            w_cmd.op     = stq_pkg::CELL_REMOVE;
                            n_res.status = stq_pkg::STAT_OK;
                        end else begin
                            n_res.status = stq_pkg::STAT_IDLE;
                        end
                    end
                    default: begin
                        n_strobe = 1'b0;
                    end
                endcase
            end
            stq_pkg::S_TICK: begin
                n_strobe = 1'b1;
                if (w_head_due) begin
                    // Emit the front slot and pull the chain forward.
                    w_cmd.op       = stq_pkg::CELL_SHIFT;
                    n_res.status   = stq_pkg::STAT_EXPIRED;
                    n_res.slot_out = stq_pkg::slot_out4(w_ent[0].slot);
                    n_res.last     = w_tick_done;
                    n_count        = r_count + stq_pkg::CNT_W'(1);
                end else begin
                    n_res.status   = stq_pkg::STAT_NONE;
                    n_res.slot_out = '0;
                    n_res.last     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= stq_pkg::S_IDLE;
            r_tick   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |=> o_strobe)
        else $error("results of one beat not back to back");

    a_req_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stq_pkg::S_REQ |=> o_strobe && o_res.last)
        else $error("request did not give exactly one result");

    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + N'(1))) == '0)
        else $error("armed cells not packed at the front of the chain");

endmodule
